// ===== hdl/atc_pkg.sv =====
package atc_pkg;

  localparam logic [1:0] ALPHA_OPAQUE   = 2'd0;
  localparam logic [1:0] ALPHA_EXPLICIT = 2'd1;
  localparam logic [1:0] ALPHA_INTERP   = 2'd2;

  // red 7:0, green 15:8, blue 23:16
  typedef logic [23:0] rgb_t;

  typedef struct packed {
    logic [63:0] alpha_block;
    logic [63:0] color_block;
  } in_t;

  typedef struct packed {
    logic [1:0]  row_index;
    logic [31:0] pixel_0;
    logic [31:0] pixel_1;
    logic [31:0] pixel_2;
    logic [31:0] pixel_3;
    logic        last_row;
  } out_t;

  // per-block data after palette build; num holds alpha level numerators
  typedef struct packed {
    rgb_t [3:0]       pal;
    logic [15:0][1:0] csel;
    logic [63:0]      ab;
    logic [1:0]       fmt;
    logic             interp7;
    logic [5:0][10:0] num;
  } prep_t;

  typedef struct packed {
    logic [1:0] csel;
    logic [3:0] nib;
    logic [2:0] asel;
  } lane_sel_t;

endpackage

// ===== hdl/atc_prep.sv =====
module atc_prep (
  input  atc_pkg::in_t   blk_i,
  input  logic [1:0]     fmt_i,
  output atc_pkg::prep_t prep_o
);
  import atc_pkg::*;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  logic [15:0]     e0, e1;
  logic [2:0][7:0] ca, cb;
  logic [7:0]      a0, a1;

  assign e0 = blk_i.color_block[15:0];
  assign e1 = blk_i.color_block[31:16];
  assign a0 = blk_i.alpha_block[7:0];
  assign a1 = blk_i.alpha_block[15:8];

  assign ca[0] = widen5(e0[14:10]);
  assign ca[1] = widen5(e0[9:5]);
  assign ca[2] = widen5(e0[4:0]);
  assign cb[0] = widen5(e1[15:11]);
  assign cb[1] = widen6(e1[10:5]);
  assign cb[2] = widen5(e1[4:0]);

  always_comb begin
    logic [10:0] s1, s2;
    logic [7:0]  q;
    prep_o = '0;
    for (int c = 0; c < 3; c++) begin
      s1 = 11'(ca[c]) * 11'd5 + 11'(cb[c]) * 11'd3;
      s2 = 11'(ca[c]) * 11'd3 + 11'(cb[c]) * 11'd5;
      q  = {2'b00, cb[c][7:2]};
      if (!e0[15]) begin
        prep_o.pal[0][8*c +: 8] = ca[c];
        prep_o.pal[1][8*c +: 8] = s1[10:3];
        prep_o.pal[2][8*c +: 8] = s2[10:3];
        prep_o.pal[3][8*c +: 8] = cb[c];
      end else begin
        prep_o.pal[0][8*c +: 8] = 8'h00;
        prep_o.pal[1][8*c +: 8] = (ca[c] > q) ? (ca[c] - q) : 8'h00;
        prep_o.pal[2][8*c +: 8] = ca[c];
        prep_o.pal[3][8*c +: 8] = cb[c];
      end
    end
    prep_o.csel    = blk_i.color_block[63:32];
    prep_o.ab      = blk_i.alpha_block;
    prep_o.fmt     = fmt_i;
    prep_o.interp7 = (a0 > a1);
    for (int i = 1; i <= 6; i++) begin
      if (a0 > a1) begin
        prep_o.num[i-1] = 11'(7 - i) * 11'(a0) + 11'(i) * 11'(a1);
      end else if (i <= 4) begin
        prep_o.num[i-1] = 11'(5 - i) * 11'(a0) + 11'(i) * 11'(a1);
      end else begin
        prep_o.num[i-1] = '0;
      end
    end
  end

endmodule

// ===== hdl/atc_alpha_lv.sv =====
module atc_alpha_lv (
  input  atc_pkg::prep_t  prep_i,
  output logic [7:0][7:0] lv_o
);
  import atc_pkg::*;

  // floor(x/7) and floor(x/5) by reciprocal, exact for x up to 1785
  localparam logic [21:0] Recip7 = 22'd2341;
  localparam logic [21:0] Recip5 = 22'd3277;

  logic [5:0][21:0] p7, p5;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      p7[i] = 22'(prep_i.num[i]) * Recip7;
      p5[i] = 22'(prep_i.num[i]) * Recip5;
    end
  end

  always_comb begin
    lv_o[0] = prep_i.ab[7:0];
    lv_o[1] = prep_i.ab[15:8];
    if (prep_i.interp7) begin
      for (int i = 0; i < 6; i++) begin
        lv_o[i+2] = p7[i][21:14];
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        lv_o[i+2] = p5[i][21:14];
      end
      lv_o[6] = 8'h00;
      lv_o[7] = 8'hff;
    end
  end

endmodule

// ===== hdl/atc_lane.sv =====
module atc_lane (
  input  atc_pkg::rgb_t [3:0] pal_i,
  input  logic [1:0]          fmt_i,
  input  logic [7:0][7:0]     lv_i,
  input  atc_pkg::lane_sel_t  sel_i,
  output logic [31:0]         pixel_o
);
  import atc_pkg::*;

  logic [7:0] alpha;

  always_comb begin
    unique case (fmt_i)
      ALPHA_EXPLICIT: alpha = {sel_i.nib, sel_i.nib};
      ALPHA_INTERP:   alpha = lv_i[sel_i.asel];
      default:        alpha = 8'hff;
    endcase
  end

  assign pixel_o = {alpha, pal_i[sel_i.csel]};

endmodule

// ===== hdl/atc_texture_block_decoder_unit.sv =====
// Channel  Signals                        Transfer
// -------  -----------------------------  ------------------------------------
// in       in_valid_i/in_ready_o/in_data  one compressed block (color + alpha)
// out      out_valid_o/out_ready_i/data   one pixel row, four RGBA8888 pixels
// cfg      APB psel/penable/pwrite/paddr  alpha_format at byte address 0
//
// A block enters a prep register (palette, alpha numerators), then sits in the
// row stage while four column lanes build one row per cycle unless the output stalls.
// The prep register can accept another block while the row stage still emits rows.
// A block passes the prep, row and output registers before its first row shows.
// Reset clears all valid flags and alpha_format; no clearing pass.
// Output stalls hold the row stage; the prep register still takes one block.
module atc_texture_block_decoder_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  atc_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output atc_pkg::out_t  out_data_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import atc_pkg::*;

  localparam logic RegAlphaFormat = 1'b0;

  logic [1:0] fmt_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == RegAlphaFormat) ? {30'b0, fmt_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= ALPHA_OPAQUE;
    end else if (cfg_wr && paddr[2] == RegAlphaFormat) begin
      fmt_q <= pwdata[1:0];
    end
  end

  prep_t prep_d, p_q, r_q;
  logic  p_valid_q, r_valid_q, o_valid_q;
  logic  [1:0] row_q;
  out_t  o_d, o_q;
  logic  in_xfer, o_load, r_free, r_load;

  atc_prep u_prep (
    .blk_i (in_data_i),
    .fmt_i (fmt_q),
    .prep_o(prep_d)
  );

  assign in_xfer    = in_valid_i & in_ready_o;
  assign o_load     = r_valid_q & (~o_valid_q | out_ready_i);
  assign r_free     = ~r_valid_q | (o_load & (row_q == 2'd3));
  assign r_load     = p_valid_q & r_free;
  assign in_ready_o = ~p_valid_q | r_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      r_valid_q <= 1'b0;
      row_q     <= '0;
      o_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        p_valid_q <= 1'b1;
      end else if (r_load) begin
        p_valid_q <= 1'b0;
      end
      if (r_load) begin
        r_valid_q <= 1'b1;
      end else if (o_load && row_q == 2'd3) begin
        r_valid_q <= 1'b0;
      end
      if (o_load) begin
        row_q <= row_q + 2'd1;
      end
      if (o_load) begin
        o_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) p_q <= prep_d;
    if (r_load)  r_q <= p_q;
    if (o_load)  o_q <= o_d;
  end

  logic [7:0][7:0]  lv;
  logic [15:0][3:0] nib_a;
  logic [15:0][2:0] asel_a;
  logic [3:0][31:0] lane_px;

  assign nib_a  = r_q.ab;
  assign asel_a = r_q.ab[63:16];

  atc_alpha_lv u_alpha_lv (
    .prep_i(r_q),
    .lv_o  (lv)
  );

  for (genvar col = 0; col < 4; col++) begin : g_lane
    lane_sel_t sel;
    assign sel.csel = r_q.csel[{row_q, 2'(col)}];
    assign sel.nib  = nib_a[{row_q, 2'(col)}];
    assign sel.asel = asel_a[{row_q, 2'(col)}];

    atc_lane u_lane (
      .pal_i  (r_q.pal),
      .fmt_i  (r_q.fmt),
      .lv_i   (lv),
      .sel_i  (sel),
      .pixel_o(lane_px[col])
    );
  end

  always_comb begin
    o_d.row_index = row_q;
    o_d.pixel_0   = lane_px[0];
    o_d.pixel_1   = lane_px[1];
    o_d.pixel_2   = lane_px[2];
    o_d.pixel_3   = lane_px[3];
    o_d.last_row  = (row_q == 2'd3);
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_q;

  a_row_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !r_valid_q |-> row_q == 2'd0)
    else $error("row counter not zero with empty row stage");

  a_in_to_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> p_valid_q)
    else $error("accepted block lost before prep register");

  a_rows_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_data_o.last_row) |=> out_valid_o)
    else $error("gap inside a block's rows");

  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_data_o.last_row) |=>
      out_data_o.row_index == $past(out_data_o.row_index) + 2'd1)
    else $error("rows out of order");

endmodule
